// ----- hw/rtl/jila_pkg.sv -----
// Package: transaction types, opcodes and pipeline structs for the JVM integer/long ALU.
package jila_pkg;

  localparam int unsigned DivSteps = 64;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_REM  = 4'd4;
  localparam logic [3:0] OP_NEG  = 4'd5;
  localparam logic [3:0] OP_SHL  = 4'd6;
  localparam logic [3:0] OP_SHR  = 4'd7;
  localparam logic [3:0] OP_USHR = 4'd8;
  localparam logic [3:0] OP_AND  = 4'd9;
  localparam logic [3:0] OP_OR   = 4'd10;
  localparam logic [3:0] OP_XOR  = 4'd11;

  localparam logic [4:0] OPS_PER_FORM = 5'd12;
  localparam logic [4:0] CMD_LIMIT = 5'd24;
  localparam logic [5:0] INT_SHIFT_MASK = 6'h1f;
  localparam logic [5:0] LONG_SHIFT_MASK = 6'h3f;

  typedef struct packed {
    logic [4:0]        cmd;
    logic signed [63:0] first;
    logic signed [63:0] second;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result;
    logic               div_zero;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic        is_long;
    logic        bad;
    logic [3:0]  op;
    logic [63:0] simple;
    logic [63:0] pp_ll;
    logic [31:0] pp_lh;
    logic [31:0] pp_hl;
    logic        neg_q;
    logic        neg_r;
    logic        dz;
  } side_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] dvs;
  } div_t;

endpackage

// ----- hw/rtl/jila_prep.sv -----
// Input stage: operand decode, simple operations, partial products, divider setup.
module jila_prep (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid,
  input  jila_pkg::in_item_t item,
  output jila_pkg::side_t   side,
  output jila_pkg::div_t    div
);

  logic        is_long;
  logic [3:0]  op;
  logic [63:0] a;
  logic [63:0] b;
  logic [5:0]  s;
  logic [63:0] ua;
  logic [63:0] ub;
  logic [63:0] simple;
  logic [4:0]  op_wide;

  always_comb begin
    is_long = item.cmd >= jila_pkg::OPS_PER_FORM;
    op_wide = is_long ? item.cmd - jila_pkg::OPS_PER_FORM : item.cmd;
    op = op_wide[3:0];
    a = is_long ? item.first : {{32{item.first[31]}}, item.first[31:0]};
    b = is_long ? item.second : {{32{item.second[31]}}, item.second[31:0]};
    s = b[5:0] & (is_long ? jila_pkg::LONG_SHIFT_MASK : jila_pkg::INT_SHIFT_MASK);
    ua = a[63] ? 64'd0 - a : a;
    ub = b[63] ? 64'd0 - b : b;
    case (op)
      jila_pkg::OP_ADD:  simple = a + b;
      jila_pkg::OP_SUB:  simple = a - b;
      jila_pkg::OP_NEG:  simple = 64'd0 - a;
      jila_pkg::OP_SHL:  simple = a << s;
      jila_pkg::OP_SHR:  simple = 64'($signed(a) >>> s);
      jila_pkg::OP_USHR: simple = is_long ? a >> s : {32'd0, a[31:0]} >> s;
      jila_pkg::OP_AND:  simple = a & b;
      jila_pkg::OP_OR:   simple = a | b;
      jila_pkg::OP_XOR:  simple = a ^ b;
      default:           simple = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else if (en) begin
      side.valid <= valid;
    end
    if (en) begin
      side.is_long <= is_long;
      side.bad     <= item.cmd >= jila_pkg::CMD_LIMIT;
      side.op      <= op;
      side.simple  <= simple;
      side.pp_ll   <= a[31:0] * b[31:0];
      side.pp_lh   <= 32'(a[31:0] * b[63:32]);
      side.pp_hl   <= 32'(a[63:32] * b[31:0]);
      side.neg_q   <= a[63] ^ b[63];
      side.neg_r   <= a[63];
      side.dz      <= b == 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div.rem <= 64'd0;
      div.quo <= ua;
      div.dvs <= ub;
    end
  end

endmodule

// ----- hw/rtl/jila_div_cell.sv -----
// Divider cell: one restoring quotient bit per cycle while en is high, carries the transaction alongside.
module jila_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  jila_pkg::side_t side_in,
  input  jila_pkg::div_t  div_in,
  output jila_pkg::side_t side,
  output jila_pkg::div_t  div
);

  logic [64:0] sh;
  logic [64:0] diff;

  always_comb begin
    sh = {div_in.rem, div_in.quo[63]};
    diff = sh - {1'b0, div_in.dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else if (en) begin
      side <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div.dvs <= div_in.dvs;
      div.rem <= diff[64] ? sh[63:0] : diff[63:0];
      div.quo <= {div_in.quo[62:0], ~diff[64]};
    end
  end

endmodule

// ----- hw/rtl/jila_final.sv -----
// Output stage: product sum, quotient/remainder sign fix, selection and int sign extension.
module jila_final (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  jila_pkg::side_t     side,
  input  jila_pkg::div_t      div,
  output logic                valid,
  output jila_pkg::out_item_t item
);

  logic [63:0] prod;
  logic [63:0] r;
  logic        dz;

  always_comb begin
    prod = side.pp_ll + {side.pp_lh + side.pp_hl, 32'd0};
    dz = 1'b0;
    case (side.op)
      jila_pkg::OP_MUL: r = prod;
      jila_pkg::OP_DIV: begin
        r = side.neg_q ? 64'd0 - div.quo : div.quo;
        dz = side.dz;
      end
      jila_pkg::OP_REM: begin
        r = side.neg_r ? 64'd0 - div.rem : div.rem;
        dz = side.dz;
      end
      default: r = side.simple;
    endcase
    if (dz) begin
      r = 64'd0;
    end
    if (!side.is_long) begin
      r = {{32{r[31]}}, r[31:0]};
    end
    if (side.bad) begin
      r = 64'd0;
      dz = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item.result   <= r;
      item.div_zero <= dz;
    end
  end

endmodule

// ----- hw/rtl/jvm_integer_long_alu_top.sv -----
// JVM int/long ALU: input stage, 64-cell divider chain, output stage.
// Throughput: one transaction per cycle; the chain advances whenever the output
// register is empty or taken, so the input is stalled only by a stalled result.
// Reset (rst, synchronous) empties every stage; no other state.
module jvm_integer_long_alu_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  jila_pkg::in_item_t  op,
  output logic                res_valid,
  input  logic                res_stall,
  output jila_pkg::out_item_t res
);

  logic            en;
  jila_pkg::side_t side [jila_pkg::DivSteps+1];
  jila_pkg::div_t  div  [jila_pkg::DivSteps+1];

  assign en = !(res_valid && res_stall);
  assign cmd_stall = !en;

  jila_prep u_prep (
    .clk(clk), .rst(rst), .en(en), .valid(cmd_valid), .item(op),
    .side(side[0]), .div(div[0])
  );

  for (genvar i = 0; i < jila_pkg::DivSteps; i++) begin : g_cell
    jila_div_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .side_in(side[i]), .div_in(div[i]),
      .side(side[i+1]), .div(div[i+1])
    );
  end

  jila_final u_final (
    .clk(clk), .rst(rst), .en(en),
    .side(side[jila_pkg::DivSteps]), .div(div[jila_pkg::DivSteps]),
    .valid(res_valid), .item(res)
  );

endmodule

// ----- test/tb.sv -----
// Testbench for the JVM int/long ALU: random and directed bytecodes checked against a predictor.
`timescale 1ns / 1ps

module tb;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_stall;
  jila_pkg::in_item_t  op = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  jila_pkg::out_item_t res;

  jvm_integer_long_alu_top DUT (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .op(op),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  always #1 clk = ~clk;

  jila_pkg::in_item_t  pending_ops[$];
  jila_pkg::out_item_t expected_results[$];
  int        errors = 0;
  int        send_idle_pct = 20;
  int        recv_idle_pct = 80;
  int        hold_len = 0;
  int        hold_cycles = 0;
  bit        hold_taken = 1'b0;
  bit        sender_paused = 1'b0;

  function automatic logic [63:0] sext32(logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic jila_pkg::out_item_t alu_predict(jila_pkg::in_item_t t);
    jila_pkg::out_item_t o;
    logic        is_long;
    logic [3:0]  code;
    logic [63:0] a, b, ua, ub, q, r, x;
    logic [5:0]  sh;
    o = '0;
    if (t.cmd >= jila_pkg::CMD_LIMIT) return o;
    is_long = t.cmd >= jila_pkg::OPS_PER_FORM;
    code = is_long ? 4'(t.cmd - jila_pkg::OPS_PER_FORM) : t.cmd[3:0];
    a = is_long ? t.first : sext32(t.first);
    b = is_long ? t.second : sext32(t.second);
    sh = b[5:0] & (is_long ? jila_pkg::LONG_SHIFT_MASK : jila_pkg::INT_SHIFT_MASK);
    x = '0;
    case (code)
      jila_pkg::OP_ADD: x = a + b;
      jila_pkg::OP_SUB: x = a - b;
      jila_pkg::OP_MUL: x = a * b;
      jila_pkg::OP_DIV, jila_pkg::OP_REM: begin
        if (b == 0) begin
          o.div_zero = 1'b1;
        end else begin
          ua = a[63] ? -a : a;
          ub = b[63] ? -b : b;
          q = ua / ub;
          r = ua % ub;
          if (code == jila_pkg::OP_REM) x = a[63] ? -r : r;
          else x = (a[63] != b[63]) ? -q : q;
        end
      end
      jila_pkg::OP_NEG: x = -a;
      jila_pkg::OP_SHL: x = a << sh;
      jila_pkg::OP_SHR: x = $signed(a) >>> sh;
      jila_pkg::OP_USHR: x = is_long ? (a >> sh) : ({32'd0, a[31:0]} >> sh);
      jila_pkg::OP_AND: x = a & b;
      jila_pkg::OP_OR: x = a | b;
      default: x = a ^ b;
    endcase
    o.result = is_long ? x : sext32(x);
    return o;
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = 64'h8000_0000_0000_0000;
      1: v = 64'h7fff_ffff_ffff_ffff;
      2: v = '0;
      3: v = '1;
      4: v = 64'($signed($urandom_range(0, 200)) - 100);
      5: v = sext32({32'd0, $urandom});
      6: v = 64'h0000_0000_8000_0000 | {32'd0, 1'b0, 31'($urandom)};
      default: ;
    endcase
    return v;
  endfunction

  task automatic push_op(logic [4:0] c, logic [63:0] a, logic [63:0] b);
    jila_pkg::in_item_t t;
    t.cmd = c;
    t.first = a;
    t.second = b;
    pending_ops.push_back(t);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || !cmd_stall) begin
      if (pending_ops.size() > 0 && !sender_paused &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        op <= pending_ops.pop_front();
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
    if (!rst && cmd_valid && !cmd_stall) expected_results.push_back(alu_predict(op));
  end

  // long receiver hold
  always @(posedge clk) begin
    if (!hold_taken && hold_len > 0) begin
      hold_cycles <= hold_len;
      hold_taken <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // receiver stall and monitor
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      res_stall <= 1'b1;
    end else begin
      res_stall <= $urandom_range(0, 99) < recv_idle_pct;
    end
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result %h", res.result);
        errors++;
      end else begin
        jila_pkg::out_item_t e;
        e = expected_results.pop_front();
        if (e.result !== res.result) begin
          $error("result: expected %h actual %h", e.result, res.result);
          errors++;
        end
        if (e.div_zero !== res.div_zero) begin
          $error("div_zero: expected %b actual %b", e.div_zero, res.div_zero);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() > 0 || cmd_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic add_random(int n);
    repeat (n) push_op(5'($urandom_range(0, 31)), rand_operand(), rand_operand());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int c = 0; c < 24; c++)
      push_op(5'(c), 64'h8000_0000_8000_0000, 64'hffff_ffff_ffff_ffff);
    push_op(5'(jila_pkg::OP_DIV), 64'd7, 64'd0);
    push_op(jila_pkg::OPS_PER_FORM + 5'(jila_pkg::OP_REM), 64'd7, 64'h1_0000_0000);
    push_op(jila_pkg::CMD_LIMIT + 5'd1, 64'd5, 64'd3);
    add_random(300);
    wait_drained();

    send_idle_pct = 80;
    recv_idle_pct = 20;
    add_random(250);
    wait_drained();
    sender_paused = 1'b1;
    repeat (10) @(posedge clk);
    sender_paused = 1'b0;

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len = 300;
    add_random(350);
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #500000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
